// File: rtl/tod_pkg.sv
`default_nettype none

package tod_pkg;

  // Sequencer states of the detector.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_MARG,
    ST_SEL,
    ST_ROOT,
    ST_FIN
  } tod_state_e;

  // Threshold mode codes; the unused code behaves as the margin mode.
  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_DYN    = 2'd1;
  localparam logic [1:0] MODE_MARGIN = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FILTER_GAIN     = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_MODE  = 3'd1;
  localparam logic [2:0] REG_MARGIN          = 3'd2;
  localparam logic [2:0] REG_FIXED_TRIP      = 3'd3;
  localparam logic [2:0] REG_FIXED_ALARM_ON  = 3'd4;
  localparam logic [2:0] REG_FIXED_ALARM_OFF = 3'd5;
  localparam logic [2:0] REG_ALARM_ON_DELTA  = 3'd6;
  localparam logic [2:0] REG_ALARM_OFF_DELTA = 3'd7;

  // Square root request and result between the top level and the root unit.
  typedef struct packed {
    logic        start;
    logic [31:0] radicand;
  } tod_sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] root;
  } tod_sqrt_res_t;

endpackage

`default_nettype wire

// File: rtl/tod_isqrt.sv
`default_nettype none

module tod_isqrt
  import tod_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tod_sqrt_req_t req_i,
  output tod_sqrt_res_t      res_o
);

  logic [31:0] x_q;
  logic [18:0] rem_q;
  logic [15:0] root_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [18:0] rem_sh;
  logic [18:0] trial;
  logic        fits;

  // One result bit per cycle: bring down two radicand bits and try root*4+1.
  assign rem_sh = {rem_q[16:0], x_q[31:30]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  // Control of the digit loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath of the digit loop.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[29:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[14:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.root = root_q;

endmodule

`default_nettype wire

// File: rtl/timed_overcurrent_detector.sv
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+---------------------------------------------
// input     | in_valid_i / in_stall_o     | square_a_i, square_b_i, square_c_i, max_current_i
// output    | out_valid_o / out_stall_i   | trip_o, alarm_o, highest_rms_o, highest_phase_o
// config    | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// Each request passes from acceptance to the result register as follows: one shared
// 17x33 multiplier runs three filter updates and the margin product, then the root
// unit builds the 16-bit root one bit at a time.
// The block takes one request at a time; in_stall_o is high while it works.
// A finished result waits in the output register; a stalled output holds the
// sequencer in its last state. Reset clears filters, alarm and registers at once.
`default_nettype none

module timed_overcurrent_detector
  import tod_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] square_a_i,
  input  wire logic [31:0] square_b_i,
  input  wire logic [31:0] square_c_i,
  input  wire logic [15:0] max_current_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             trip_o,
  output logic             alarm_o,
  output logic [15:0]      highest_rms_o,
  output logic [1:0]       highest_phase_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers.
  logic [15:0] gain_q;
  logic [1:0]  mode_q;
  logic [15:0] margin_q;
  logic [15:0] fix_trip_q;
  logic [15:0] fix_on_q;
  logic [15:0] fix_off_q;
  logic [15:0] on_delta_q;
  logic [15:0] off_delta_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= 16'd0;
      mode_q      <= MODE_FIXED;
      margin_q    <= 16'd4096;
      fix_trip_q  <= 16'hFFFF;
      fix_on_q    <= 16'hFFFF;
      fix_off_q   <= 16'd0;
      on_delta_q  <= 16'd0;
      off_delta_q <= 16'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FILTER_GAIN:     gain_q      <= pwdata[15:0];
        REG_THRESHOLD_MODE:  mode_q      <= pwdata[1:0];
        REG_MARGIN:          margin_q    <= pwdata[15:0];
        REG_FIXED_TRIP:      fix_trip_q  <= pwdata[15:0];
        REG_FIXED_ALARM_ON:  fix_on_q    <= pwdata[15:0];
        REG_FIXED_ALARM_OFF: fix_off_q   <= pwdata[15:0];
        REG_ALARM_ON_DELTA:  on_delta_q  <= pwdata[15:0];
        REG_ALARM_OFF_DELTA: off_delta_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_idx)
      REG_FILTER_GAIN:     prdata = {16'd0, gain_q};
      REG_THRESHOLD_MODE:  prdata = {30'd0, mode_q};
      REG_MARGIN:          prdata = {16'd0, margin_q};
      REG_FIXED_TRIP:      prdata = {16'd0, fix_trip_q};
      REG_FIXED_ALARM_ON:  prdata = {16'd0, fix_on_q};
      REG_FIXED_ALARM_OFF: prdata = {16'd0, fix_off_q};
      REG_ALARM_ON_DELTA:  prdata = {16'd0, on_delta_q};
      REG_ALARM_OFF_DELTA: prdata = {16'd0, off_delta_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Sequencer.
  tod_state_e state_q, state_d;
  logic [1:0] ph_q, ph_d;
  logic       in_acc;
  logic       out_load;
  logic       out_valid_q;

  tod_sqrt_req_t sq_req;
  tod_sqrt_res_t sq_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MUL;
          ph_d    = 2'd0;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (ph_q == 2'd2) begin
          state_d = ST_MARG;
        end else begin
          ph_d    = ph_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_MARG: state_d = ST_SEL;
      ST_SEL:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (sq_res.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Captured request and filter state.
  logic [31:0] sq_q   [3];
  logic [31:0] filt_q [3];
  logic [15:0] imax_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sq_q[0] <= square_a_i;
      sq_q[1] <= square_b_i;
      sq_q[2] <= square_c_i;
      imax_q  <= max_current_i;
    end
  end

  // Shared multiplier: unsigned 16-bit factor times signed 33-bit factor.
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] prod_q;

  always_comb begin
    if (state_q == ST_MARG) begin
      mul_a = signed'({1'b0, margin_q});
      mul_b = signed'({17'd0, imax_q});
    end else begin
      mul_a = signed'({1'b0, gain_q});
      mul_b = signed'({1'b0, sq_q[ph_q]}) - signed'({1'b0, filt_q[ph_q]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL || state_q == ST_MARG) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Filter update: add the product shifted right arithmetically by 16.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q[0] <= '0;
      filt_q[1] <= '0;
      filt_q[2] <= '0;
    end else if (state_q == ST_ACC) begin
      filt_q[ph_q] <= filt_q[ph_q] + prod_q[47:16];
    end
  end

  // Phase selection: A beats B only when strictly larger, C only when larger.
  logic [31:0] best;
  logic [1:0]  best_ph;
  logic [1:0]  best_ph_q;

  always_comb begin
    if (filt_q[0] > filt_q[1]) begin
      best    = filt_q[0];
      best_ph = 2'd0;
    end else begin
      best    = filt_q[1];
      best_ph = 2'd1;
    end
    if (filt_q[2] > best) begin
      best    = filt_q[2];
      best_ph = 2'd2;
    end
  end

  // Thresholds for this request.
  logic [15:0] trip_lvl, on_lvl, off_lvl;
  logic [15:0] trip_lvl_q, on_lvl_q, off_lvl_q;
  logic [15:0] marg_lvl;

  assign marg_lvl = (prod_q[31:28] != 4'd0) ? 16'hFFFF : prod_q[27:12];

  always_comb begin
    case (mode_q)
      MODE_FIXED: begin
        trip_lvl = fix_trip_q;
        on_lvl   = fix_on_q;
        off_lvl  = fix_off_q;
      end
      MODE_DYN: begin
        trip_lvl = imax_q;
        on_lvl   = (trip_lvl > on_delta_q) ? trip_lvl - on_delta_q : 16'd0;
        off_lvl  = (on_lvl > off_delta_q) ? on_lvl - off_delta_q : 16'd0;
      end
      default: begin
        trip_lvl = marg_lvl;
        on_lvl   = (trip_lvl > on_delta_q) ? trip_lvl - on_delta_q : 16'd0;
        off_lvl  = (on_lvl > off_delta_q) ? on_lvl - off_delta_q : 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      best_ph_q  <= best_ph;
      trip_lvl_q <= trip_lvl;
      on_lvl_q   <= on_lvl;
      off_lvl_q  <= off_lvl;
    end
  end

  // Square root of the selected filtered square.
  assign sq_req.start    = (state_q == ST_SEL);
  assign sq_req.radicand = best;

  tod_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .res_o  (sq_res)
  );

  // Output register and alarm hysteresis.
  logic        alarm_q;
  logic        alarm_d;
  logic        trip_q;
  logic [15:0] rms_q;
  logic [1:0]  phase_q;
  logic [15:0] root_hold_q;

  always_ff @(posedge clk_i) begin
    if (sq_res.done) begin
      root_hold_q <= sq_res.root;
    end
  end

  always_comb begin
    alarm_d = alarm_q;
    if (root_hold_q >= on_lvl_q) begin
      alarm_d = 1'b1;
    end else if (root_hold_q <= off_lvl_q) begin
      alarm_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      alarm_q     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        alarm_q     <= alarm_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      trip_q  <= (root_hold_q >= trip_lvl_q);
      rms_q   <= root_hold_q;
      phase_q <= best_ph_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trip_o          = trip_q;
  assign alarm_o         = alarm_q;
  assign highest_rms_o   = rms_q;
  assign highest_phase_o = phase_q;

`ifndef SYNTH
  // A taken request keeps the input side stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // The root unit finishes only while the sequencer waits for it.
  a_root_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_res.done |-> (state_q == ST_ROOT))
    else $error("square root finished outside its wait state");

  // A result is never overwritten while it is stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !out_load)
    else $error("stalled result overwritten");

  // The selected phase is always one of the three phases.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (highest_phase_o != 2'd3))
    else $error("selected phase out of range");
`endif

endmodule

`default_nettype wire

// File: tb/tb_timed_overcurrent_detector.sv
`timescale 1ns / 100ps

module tb_timed_overcurrent_detector
  import tod_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int TICKS_PER_PHASE = 96;
  localparam int IDLE_PERCENT = 31;

  // The code left unused by the mode list behaves as the margin mode.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Phase selection codes on highest_phase_o.
  localparam logic [1:0] PHASE_A = 2'd0;
  localparam logic [1:0] PHASE_B = 2'd1;
  localparam logic [1:0] PHASE_C = 2'd2;

  typedef struct packed {
    logic [31:0] sq_a;
    logic [31:0] sq_b;
    logic [31:0] sq_c;
    logic [15:0] imax;
  } tick_request_t;

  typedef struct packed {
    logic        trip;
    logic        alarm;
    logic [15:0] rms;
    logic [1:0]  phase;
  } tick_result_t;

  // Clock, reset and block ports.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [31:0] square_a = '0;
  logic [31:0] square_b = '0;
  logic [31:0] square_c = '0;
  logic [15:0] max_current = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic        trip_o;
  logic        alarm_o;
  logic [15:0] highest_rms_o;
  logic [1:0]  highest_phase_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Register copies as last written.
  logic [15:0] cfg_gain = 16'd0;
  logic [1:0]  cfg_mode = MODE_FIXED;
  logic [15:0] cfg_margin = 16'd4096;
  logic [15:0] cfg_trip = 16'hFFFF;
  logic [15:0] cfg_alarm_on = 16'hFFFF;
  logic [15:0] cfg_alarm_off = 16'd0;
  logic [15:0] cfg_on_delta = 16'd0;
  logic [15:0] cfg_off_delta = 16'd0;

  // Filter and alarm state of the detector as predicted.
  logic [31:0] smoothed_a = '0;
  logic [31:0] smoothed_b = '0;
  logic [31:0] smoothed_c = '0;
  logic        alarm_latched = 1'b0;

  tick_request_t pending_ticks[$];
  tick_result_t  predicted_results[$];
  tick_request_t cur_req;

  int unsigned ticks_queued = 0;
  int unsigned ticks_checked = 0;
  int unsigned trips_seen = 0;
  int unsigned alarms_seen = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          steady_flow = 1'b0;
  bit          hold_pending = 1'b0;
  logic [1:0]  mode_plan [RANDOM_PHASES] =
    '{MODE_FIXED, MODE_DYN, MODE_MARGIN, MODE_UNUSED, MODE_FIXED, MODE_DYN};

  timed_overcurrent_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .square_a_i     (square_a),
    .square_b_i     (square_b),
    .square_c_i     (square_c),
    .max_current_i  (max_current),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .trip_o         (trip_o),
    .alarm_o        (alarm_o),
    .highest_rms_o  (highest_rms_o),
    .highest_phase_o(highest_phase_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // First-order smoothing step; the step is floored, so negative errors round down.
  function automatic logic [31:0] smooth_step(input logic [31:0] mag,
                                              input logic [31:0] sq);
    longint err;
    longint prod;
    err = longint'({32'd0, sq}) - longint'({32'd0, mag});
    prod = longint'({48'd0, cfg_gain}) * err;
    return mag + 32'(prod >>> 16);
  endfunction

  // Floor square root, built up one result bit at a time from the top.
  function automatic logic [15:0] floor_root(input logic [31:0] x);
    logic [15:0] root;
    logic [15:0] trial;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (16'd1 << i);
      if (64'(trial) * 64'(trial) <= 64'(x)) root = trial;
    end
    return root;
  endfunction

  function automatic logic [15:0] floor_sub(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : 16'd0;
  endfunction

  function automatic int unsigned clamp16(input longint v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return int'(v);
  endfunction

  // Advances the filters and the alarm by one tick and returns the expected result.
  function automatic tick_result_t predict_tick(input tick_request_t req);
    tick_result_t res;
    logic [31:0] best;
    logic [31:0] scaled;
    logic [15:0] trip_lvl;
    logic [15:0] on_lvl;
    logic [15:0] off_lvl;
    smoothed_a = smooth_step(smoothed_a, req.sq_a);
    smoothed_b = smooth_step(smoothed_b, req.sq_b);
    smoothed_c = smooth_step(smoothed_c, req.sq_c);
    if (smoothed_a > smoothed_b) begin
      best = smoothed_a;
      res.phase = PHASE_A;
    end else begin
      best = smoothed_b;
      res.phase = PHASE_B;
    end
    if (smoothed_c > best) begin
      best = smoothed_c;
      res.phase = PHASE_C;
    end
    res.rms = floor_root(best);
    if (cfg_mode == MODE_FIXED) begin
      trip_lvl = cfg_trip;
      on_lvl = cfg_alarm_on;
      off_lvl = cfg_alarm_off;
    end else begin
      if (cfg_mode == MODE_DYN) begin
        trip_lvl = req.imax;
      end else begin
        scaled = (32'(req.imax) * 32'(cfg_margin)) >> 12;
        trip_lvl = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
      end
      on_lvl = floor_sub(trip_lvl, cfg_on_delta);
      off_lvl = floor_sub(on_lvl, cfg_off_delta);
    end
    res.trip = (res.rms >= trip_lvl);
    if (res.rms >= on_lvl) alarm_latched = 1'b1;
    else if (res.rms <= off_lvl) alarm_latched = 1'b0;
    res.alarm = alarm_latched;
    return res;
  endfunction

  // Request driver: holds a stalled request, otherwise offers the next one or idles.
  always @(posedge clk_i) begin : request_driver
    bit offer;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predicted_results.push_back(predict_tick(cur_req));
      end
      if (!in_valid || !in_stall_o) begin
        offer = (pending_ticks.size() != 0) &&
                (steady_flow || $urandom_range(99) >= IDLE_PERCENT);
        if (offer) begin
          cur_req = pending_ticks.pop_front();
          square_a <= cur_req.sq_a;
          square_b <= cur_req.sq_b;
          square_c <= cur_req.sq_c;
          max_current <= cur_req.imax;
        end
        in_valid <= offer;
      end
    end
  end

  // Result stall: random back-pressure, plus one long hold when asked for.
  always @(posedge clk_i) begin : result_stall
    int hold_left;
    if (hold_pending) begin
      hold_left = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    tick_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result with none expected: trip %0b alarm %0b rms %0d phase %0d",
                 $time, trip_o, alarm_o, highest_rms_o, highest_phase_o);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        if (trip_o !== want.trip) begin
          $display("%0t: trip expected %0b, got %0b", $time, want.trip, trip_o);
          errors++;
        end
        if (alarm_o !== want.alarm) begin
          $display("%0t: alarm expected %0b, got %0b", $time, want.alarm, alarm_o);
          errors++;
        end
        if (highest_rms_o !== want.rms) begin
          $display("%0t: highest_rms expected %0d, got %0d", $time, want.rms, highest_rms_o);
          errors++;
        end
        if (highest_phase_o !== want.phase) begin
          $display("%0t: highest_phase expected %0d, got %0d",
                   $time, want.phase, highest_phase_o);
          errors++;
        end
        if (want.trip) trips_seen++;
        if (want.alarm) alarms_seen++;
        ticks_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d of %0d results checked",
               $time, ticks_checked, ticks_queued);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_tick(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [15:0] imax);
    tick_request_t req;
    req.sq_a = a;
    req.sq_b = b;
    req.sq_c = c;
    req.imax = imax;
    pending_ticks.push_back(req);
    ticks_queued++;
  endtask

  // Waits until every queued request has produced its result, then lets the block settle.
  task automatic drain();
    while (ticks_checked != ticks_queued) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FILTER_GAIN:     cfg_gain = value;
      REG_THRESHOLD_MODE:  cfg_mode = value[1:0];
      REG_MARGIN:          cfg_margin = value;
      REG_FIXED_TRIP:      cfg_trip = value;
      REG_FIXED_ALARM_ON:  cfg_alarm_on = value;
      REG_FIXED_ALARM_OFF: cfg_alarm_off = value;
      REG_ALARM_ON_DELTA:  cfg_on_delta = value;
      REG_ALARM_OFF_DELTA: cfg_off_delta = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] gain, input logic [1:0] mode,
                           input logic [15:0] marg, input logic [15:0] trip_lvl,
                           input logic [15:0] on_lvl, input logic [15:0] off_lvl,
                           input logic [15:0] on_d, input logic [15:0] off_d);
    write_reg(REG_FILTER_GAIN, gain);
    write_reg(REG_THRESHOLD_MODE, {14'd0, mode});
    write_reg(REG_MARGIN, marg);
    write_reg(REG_FIXED_TRIP, trip_lvl);
    write_reg(REG_FIXED_ALARM_ON, on_lvl);
    write_reg(REG_FIXED_ALARM_OFF, off_lvl);
    write_reg(REG_ALARM_ON_DELTA, on_d);
    write_reg(REG_ALARM_OFF_DELTA, off_d);
  endtask

  // Stimulus: directed ticks, then random phases under varied settings.
  initial begin : stimulus
    int unsigned level;
    int unsigned spread;
    int unsigned base;
    int unsigned cur;
    logic [15:0] gain;
    logic [15:0] marg;
    logic [31:0] sq [3];
    logic [15:0] imax;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero gain keeps the filters at rest.
    queue_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    queue_tick(32'd0, 32'd0, 32'd0, 16'd0);
    drain();

    // Fixed levels with full gain: extremes, phase ties and the hysteresis band.
    write_all(16'hFFFF, MODE_FIXED, 16'd4096, 16'd1000, 16'd900, 16'd800, 16'd0, 16'd0);
    queue_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    queue_tick(32'd0, 32'd0, 32'd0, 16'd0);
    queue_tick(32'd0, 32'd0, 32'd0, 16'd0);
    queue_tick(32'd1000000, 32'd500000, 32'd0, 16'd1000);
    queue_tick(32'd810000, 32'd810000, 32'd810000, 16'd900);
    queue_tick(32'd810000, 32'd810000, 32'd810000, 16'd900);
    queue_tick(32'd0, 32'd0, 32'd722500, 16'd850);
    queue_tick(32'd0, 32'd600000, 32'd0, 16'd700);
    queue_tick(32'd722500, 32'd0, 32'd722500, 16'd850);
    drain();

    // Dynamic levels from the maximum current.
    write_all(16'hFFFF, MODE_DYN, 16'd4096, 16'd1000, 16'd900, 16'd800, 16'd100, 16'd50);
    queue_tick(32'd1000000, 32'd0, 32'd0, 16'd0);
    queue_tick(32'd1000000, 32'd0, 32'd0, 16'hFFFF);
    queue_tick(32'd1000000, 32'd0, 32'd0, 16'd1050);
    queue_tick(32'd1000000, 32'd0, 32'd0, 16'd1200);
    drain();

    // Margin mode with saturation of the trip level and of both subtractions.
    write_all(16'hFFFF, MODE_MARGIN, 16'hFFFF, 16'd1000, 16'd900, 16'd800,
              16'hFFFF, 16'hFFFF);
    queue_tick(32'h8000_0000, 32'd0, 32'd0, 16'hFFFF);
    queue_tick(32'd0, 32'd0, 32'd0, 16'd0);
    drain();

    // The unused mode code with a zero margin.
    write_reg(REG_THRESHOLD_MODE, {14'd0, MODE_UNUSED});
    write_reg(REG_MARGIN, 16'd0);
    queue_tick(32'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
    queue_tick(32'd4, 32'd4, 32'd9, 16'd3);
    drain();

    // Random phases, each with its own current level and register settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      level = $urandom_range(60000, 64);
      spread = level / 4 + 1;
      gain = (p == 0) ? 16'hFFFF : (p == 4) ? 16'd1 : 16'($urandom_range(65535, 1024));
      marg = (p == 2) ? 16'hFFFF : (p == 3) ? 16'd0 : 16'($urandom_range(12288, 2048));
      write_all(gain, mode_plan[p], marg,
                16'(clamp16(level + level / 8)), 16'(level), 16'(level - level / 8),
                (p == 5) ? 16'hFFFF : 16'($urandom_range(level / 8)),
                (p == 1) ? 16'hFFFF : 16'($urandom_range(level / 8)));
      base = (mode_plan[p] == MODE_FIXED || mode_plan[p] == MODE_DYN || marg == 0) ?
             level : clamp16(longint'(level) * 4096 / marg);
      if (p == 1) hold_pending = 1'b1;
      steady_flow = (p == 3);
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(99) < 15) begin
            sq[k] = $urandom;
          end else begin
            cur = clamp16(longint'(level) + $urandom_range(2 * spread) - spread);
            sq[k] = cur * cur + $urandom_range(2 * cur);
          end
        end
        if ($urandom_range(99) < 10) imax = 16'($urandom_range(65535));
        else imax = 16'(clamp16(longint'(base) + $urandom_range(base / 2) - base / 4));
        queue_tick(sq[0], sq[1], sq[2], imax);
      end
      drain();
      steady_flow = 1'b0;
    end

    $display("Checked %0d ticks over %0d register settings in all threshold modes.",
             ticks_checked, RANDOM_PHASES + 5);
    $display("Results with trip set: %0d, with alarm set: %0d, mismatches: %0d.",
             trips_seen, alarms_seen, errors);
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: timed_overcurrent_detector.f
rtl/tod_pkg.sv
rtl/tod_isqrt.sv
rtl/timed_overcurrent_detector.sv
tb/tb_timed_overcurrent_detector.sv
